@@ rtl/core/vaos_pkg.sv @@
// Shared types and constants for the voice allocator with oldest-note stealing.
package vaos_pkg;

	localparam int NOTE_W  = 5;
	localparam int VOICE_W = 3;
	localparam int STAMP_W = 64;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_FREE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_STOLEN  = 2'd1;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
	localparam logic [STAT_W-1:0] ST_RELEASE = 2'd3;

	localparam logic ACT_NOTE_ON = 1'b0;
	localparam logic ACT_DONE    = 1'b1;

	typedef struct packed {
		logic               action;
		logic [NOTE_W-1:0]  note_index;
		logic [VOICE_W-1:0] done_voice;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VOICE_W-1:0] voice;
		logic [NOTE_W-1:0]  note_out;
		logic [STAMP_W-1:0] generation;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rel_apply;
		logic bad_note;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic note_bad;
		logic idle_hit;
		logic last;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/vaos_ctrl.sv @@
// Controller state machine for the voice allocator.
module vaos_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vaos_pkg::sts_t sts,
	output vaos_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_COMMIT = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.action == vaos_pkg::ACT_DONE) begin
					cmd.rel_apply = 1'b1;
					state_d       = S_FINISH;
				end else if (sts.note_bad) begin
					cmd.bad_note = 1'b1;
					state_d      = S_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.idle_hit || sts.last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/vaos_dp.sv @@
// Datapath: voice flags, stamp memory, scan/min tracking and output register.
module vaos_dp #(
	parameter int NUM_VOICES = 8,
	parameter int NOTE_COUNT = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vaos_pkg::cmd_t cmd,
	output vaos_pkg::sts_t sts,
	input  vaos_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vaos_pkg::rsp_t rsp
);

	localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	vaos_pkg::req_t                       item_q;
	logic [NUM_VOICES-1:0]                active_q;
	logic [vaos_pkg::STAMP_W-1:0]         stamp_mem [NUM_VOICES];
	logic [vaos_pkg::STAMP_W-1:0]         rd_q;
	logic [vaos_pkg::STAMP_W-1:0]         min_q;
	logic [vaos_pkg::STAMP_W-1:0]         next_q;
	logic [IW-1:0]                        idx_q;
	logic [IW-1:0]                        pick_q;
	logic                                 steal_q;
	vaos_pkg::rsp_t                       res_q;
	vaos_pkg::rsp_t                       rsp_q;
	logic                                 rsp_valid_q;
	logic                                 dv_ok;
	logic [IW-1:0]                        dv_idx;

	assign dv_ok  = (32'(item_q.done_voice) < 32'(NUM_VOICES));
	assign dv_idx = IW'(item_q.done_voice);

	assign sts.action   = item_q.action;
	assign sts.note_bad = (32'(item_q.note_index) >= 32'(NOTE_COUNT));
	assign sts.idle_hit = !active_q[idx_q];
	assign sts.last     = (idx_q == IW'(NUM_VOICES - 1));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stamp memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stamp_mem[pick_q] <= next_q;
		end
		if (cmd.scan_start) begin
			rd_q <= stamp_mem[0];
		end else if (cmd.scan_step && !sts.last) begin
			rd_q <= stamp_mem[idx_q + IW'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			next_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.rel_apply && dv_ok) begin
				active_q[dv_idx] <= 1'b0;
			end
			if (cmd.commit) begin
				active_q[pick_q] <= 1'b1;
				next_q           <= next_q + 64'd1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + IW'(1);
			// first idle voice wins; otherwise track the oldest, lowest index on ties
			if (sts.idle_hit) begin
				pick_q  <= idx_q;
				steal_q <= 1'b0;
			end else if ((idx_q == '0) || (rd_q < min_q)) begin
				min_q   <= rd_q;
				pick_q  <= idx_q;
				steal_q <= 1'b1;
			end
		end
		if (cmd.rel_apply) begin
			res_q <= '{status: vaos_pkg::ST_RELEASE, voice: item_q.done_voice,
				note_out: '0, generation: '0};
		end else if (cmd.bad_note) begin
			res_q <= '{status: vaos_pkg::ST_INVALID, voice: '0,
				note_out: '0, generation: '0};
		end else if (cmd.commit) begin
			res_q <= '{status: (steal_q ? vaos_pkg::ST_STOLEN : vaos_pkg::ST_FREE),
				voice: vaos_pkg::VOICE_W'(pick_q),
				note_out: item_q.note_index, generation: next_q};
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

endmodule

@@ rtl/core/voice_allocator_oldest_steal_core.sv @@
// Top level of the polyphonic voice allocator with oldest-note stealing.
// Each request transaction is either a note-on (action 0) or a voice-done event
// (action 1) and yields exactly one response transaction. A note-on takes the
// lowest-index idle voice (status 0) or, when every voice is busy, steals the voice
// with the smallest start stamp, lowest index on a tie (status 1); the voice is
// stamped with a 64-bit generation counter that then increments and wraps. Notes at
// or above NOTE_COUNT return status 2 with zero fields and change nothing. A
// voice-done clears the named voice's active flag (ignored if out of range) and
// returns status 3 echoing the voice. Timing: one transaction is in work at a time.
// Voice-done and invalid notes go from decode straight to the finish state; a note-on
// first runs the voice scan, which stops at the first idle voice or goes through every
// voice when one must be stolen, and then commits. The scan reads one stamp per cycle
// from the single-read-port stamp memory and compares it against the running minimum.
// The response sits in an output register, so a new request is taken while an earlier
// response still waits.
module voice_allocator_oldest_steal_core #(
	parameter int NUM_VOICES = 8,
	parameter int NOTE_COUNT = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vaos_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vaos_pkg::rsp_t rsp
);

	vaos_pkg::cmd_t cmd;
	vaos_pkg::sts_t sts;

	// sequencing: decode, scan, commit, hand off to the response register
	vaos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// voice state, stamp memory, generation counter and response register
	vaos_dp #(
		.NUM_VOICES (NUM_VOICES),
		.NOTE_COUNT (NOTE_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// at most one datapath command per cycle
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rel_apply, cmd.bad_note, cmd.scan_start,
			cmd.scan_step, cmd.commit, cmd.out_load}))
		else $error("datapath commands overlap");

	// a pending response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && rsp_valid && rsp_stall))
		else $error("response register overwritten while stalled");

	// the last scan step always leads straight into the commit
	a_scan_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && sts.last) |=> cmd.commit)
		else $error("scan end not followed by commit");

	// only one transaction in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request accepted while busy");

endmodule
